[hdl/hcdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and item codes for the histogram CDF builder.
// No dependencies; the interfaces and the top level import this package.

package hcdf_pkg;

  // Sizing of the histogram and of the fixed-point answer.
  localparam int MAX_BINS      = 1024;
  localparam int PIXEL_BITS    = 24;
  localparam int FRACTION_BITS = 16;

  // Field widths of the words on the channels and of the register.
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 25;
  localparam int INDEX_W = 10;
  localparam int FRAC_W  = FRACTION_BITS + 1;
  localparam int CFG_W   = 11;

  // Internal widths.
  localparam int ADDR_W  = $clog2(MAX_BINS);
  localparam int TOTAL_W = PIXEL_BITS + 1;
  localparam int SUM_W   = ((TOTAL_W > COUNT_W) ? TOTAL_W : COUNT_W) + 1;

  // One quotient bit per divider step, including the integer bit.
  localparam int DIV_STEPS = FRACTION_BITS + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [TOTAL_W-1:0] PIXEL_BOUND = TOTAL_W'(1) << PIXEL_BITS;
  localparam logic [FRAC_W-1:0]  FULL_SCALE  = FRAC_W'(1) << FRACTION_BITS;
  localparam logic [CFG_W-1:0]   BINS_RESET  = CFG_W'(1024);
  localparam logic [CFG_W-1:0]   BINS_CAP    = CFG_W'(MAX_BINS);

  // Item kinds carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

endpackage

`default_nettype wire

[hdl/hcdf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the histogram CDF builder.
// Depends on hcdf_pkg for the field widths.

interface hcdf_in_if import hcdf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COUNT_W-1:0] bin_count;
  logic [INDEX_W-1:0] bin_index;

  modport source (output valid, kind, bin_count, bin_index, input ready);
  modport sink   (input valid, kind, bin_count, bin_index, output ready);
endinterface

interface hcdf_out_if import hcdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] cdf_fraction;

  modport source (output valid, cdf_fraction, input ready);
  modport sink   (input valid, cdf_fraction, output ready);
endinterface

`default_nettype wire

[hdl/histogram_cdf_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Histogram CDF builder: prefix-sum store and bit-serial normalizing divider.
// Depends on hcdf_pkg and on the channel interfaces in hcdf_if.sv.
//
//   Channel     Dir  Handshake      Word
//   item_in     in   valid/ready    kind, bin_count, bin_index
//   result_out  out  valid/ready    cdf_fraction (Q1.16, 65536 is one)
//   cfg         in   cfg_write      cfg_wdata -> bins_in_use
//
// Clear, load and unused words produce no result. A read of a loaded bin is
// accepted and addresses the prefix memory, waits in S_READ for the registered
// read data, runs 17 steps of the restoring divider (one quotient bit per
// cycle) and then moves the quotient to the output register. A read on an
// empty total or an unloaded bin goes straight to the done state.
// Reset is synchronous; the prefix memory needs no clearing pass because only
// entries below the fill count bins_loaded are ever used.
// The output register lets the next word be accepted while a result waits;
// a finished quotient waits in the done state only if that register is full.

module histogram_cdf_builder import hcdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  hcdf_in_if.sink               item_in,
  hcdf_out_if.source            result_out
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // Control state.
  logic [CFG_W-1:0]   bins_in_use;
  logic [CFG_W-1:0]   bins_loaded;
  logic [TOTAL_W-1:0] running_total;
  logic [STEP_W-1:0]  steps_left;
  logic               out_valid;

  // Payload state.
  logic [TOTAL_W-1:0] prefix_store [MAX_BINS];
  logic [TOTAL_W-1:0] rd_data;
  logic [TOTAL_W-1:0] rem;
  logic [FRAC_W-1:0]  quot;
  logic [FRAC_W-1:0]  out_data;

  logic               accept;
  logic               out_free;
  logic [CFG_W-1:0]   load_limit;
  logic               load_ok;
  logic [SUM_W-1:0]   load_sum;
  logic [TOTAL_W-1:0] load_total;
  logic               read_empty;
  logic               read_unloaded;
  logic [TOTAL_W:0]   trial;
  logic               fits;
  logic [TOTAL_W-1:0] rem_kept;

  assign accept   = item_in.valid && item_in.ready;
  assign out_free = !out_valid || result_out.ready;

  assign item_in.ready           = (state == S_IDLE);
  assign result_out.valid        = out_valid;
  assign result_out.cdf_fraction = out_data;

  // A load appends only while the fill count is below the smaller of the
  // configured bin count and the memory depth.
  assign load_limit = (bins_in_use > BINS_CAP) ? BINS_CAP : bins_in_use;
  assign load_ok    = (bins_loaded < load_limit);

  // The running total saturates at the pixel bound.
  assign load_sum   = SUM_W'(running_total) + SUM_W'(item_in.bin_count);
  assign load_total = (load_sum > SUM_W'(PIXEL_BOUND)) ? PIXEL_BOUND
                                                       : load_sum[TOTAL_W-1:0];

  // Special reads: an empty total wins over an unloaded bin.
  assign read_empty    = (running_total == '0);
  assign read_unloaded = (CFG_W'(item_in.bin_index) >= bins_loaded);

  // One restoring-division step: subtract the total if it fits.
  assign trial    = {1'b0, rem} - {1'b0, running_total};
  assign fits     = !trial[TOTAL_W];
  assign rem_kept = fits ? trial[TOTAL_W-1:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bins_in_use   <= BINS_RESET;
      bins_loaded   <= '0;
      running_total <= '0;
      steps_left    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        bins_in_use <= cfg_wdata;
      end

      // A finished quotient fills the output register; otherwise a taken
      // result empties it.
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (item_in.kind)
              KIND_CLEAR: begin
                running_total <= '0;
                bins_loaded   <= '0;
              end
              KIND_LOAD: begin
                if (load_ok) begin
                  running_total <= load_total;
                  bins_loaded   <= bins_loaded + CFG_W'(1);
                end
              end
              KIND_READ: begin
                if (read_empty || read_unloaded) begin
                  state <= S_DONE;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          steps_left <= STEP_W'(DIV_STEPS);
          state      <= S_DIV;
        end
        S_DIV: begin
          steps_left <= steps_left - STEP_W'(1);
          if (steps_left == STEP_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Prefix memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && (item_in.kind == KIND_LOAD) && load_ok) begin
      prefix_store[bins_loaded[ADDR_W-1:0]] <= load_total;
    end
    rd_data <= prefix_store[item_in.bin_index[ADDR_W-1:0]];
  end

  // Divider datapath and output register.
  always_ff @(posedge clk) begin
    if (accept && (item_in.kind == KIND_READ)) begin
      quot <= read_empty ? '0 : FULL_SCALE;
    end

    if (state == S_READ) begin
      rem <= rd_data;
    end

    if (state == S_DIV) begin
      // The kept remainder is below the total, so its top bit is clear.
      rem  <= {rem_kept[TOTAL_W-2:0], 1'b0};
      quot <= {quot[FRAC_W-2:0], fits};
    end

    if ((state == S_DONE) && out_free) begin
      out_data <= quot;
    end
  end

  // The total never passes the pixel bound.
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    running_total <= PIXEL_BOUND)
    else $error("running total above pixel bound");

  // The fill count never passes the memory depth.
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    bins_loaded <= BINS_CAP)
    else $error("fill count above memory depth");

  // The divider only runs on a nonzero total and with steps remaining.
  a_div_operands: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((running_total != '0) && (steps_left != '0)))
    else $error("divider running with no total or no steps");

  // A finished quotient never exceeds one.
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (quot <= FULL_SCALE))
    else $error("quotient above full scale");

  // A read of a loaded bin enters the divider right after the memory read.
  a_read_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_DIV))
    else $error("memory read not followed by division");

endmodule

`default_nettype wire
